// ===== hdl/rational_bezier_point_and_derivatives_assert.svh =====
// Assertion macros shared by the evaluator RTL.
`ifndef RATIONAL_BEZIER_POINT_AND_DERIVATIVES_ASSERT_SVH
`define RATIONAL_BEZIER_POINT_AND_DERIVATIVES_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define RBZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RBZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rbz_pkg.sv =====
`timescale 1ns / 1ps

package rbz_pkg;

    // Geometry
    localparam int DIMENSION = 3;

    // Field widths
    localparam int TW = 17;     // t, unsigned Q1.16
    localparam int PW = 32;     // control point coordinate, Q16.16
    localparam int OW = 48;     // result, Q32.16

    // Internal widths
    localparam int XW   = 35;   // coefficient numerator before scaling, Q30
    localparam int QW   = 30;   // quotient magnitude bits
    localparam int AW   = 60;   // dividend magnitude bits
    localparam int NUMW = AW + 1;
    localparam int DW   = 32;   // divisor (twice the Q30 weight power)
    localparam int RW   = 32;   // partial remainder
    localparam int CW   = QW + 1;   // signed coefficient, Q7.24

    localparam int COEF_FRAC = 24;
    localparam int OUT_SHIFT = 24;

    // Pipeline depths
    localparam int COEF_STAGES = 9;
    localparam int DIV_STAGES  = QW + 1;
    localparam int MAC_STAGES  = 3;
    localparam int PT_DEPTH    = COEF_STAGES + DIV_STAGES;
    localparam int LATENCY     = COEF_STAGES + DIV_STAGES + MAC_STAGES;

    // Constants
    localparam logic [TW-1:0]        ONE_Q16   = 17'd65536;
    localparam logic signed [31:0]   SQRT2_Q30 = 32'sd1518500250;
    localparam logic signed [31:0]   WPP_Q30   = 32'sd1257966796;  // 4 - 2*sqrt(2)
    localparam logic signed [32:0]   BPP_END   = 33'sd2147483648;
    localparam logic signed [32:0]   BPP_MID   = -33'sd3037000500;
    localparam logic [2:0][32:0]     BPP       = {BPP_END, BPP_MID, BPP_END};
    localparam logic signed [63:0]   MAX48     = 64'sd140737488355327;
    localparam logic signed [63:0]   MIN48     = -64'sd140737488355328;

    typedef logic [2:0][2:0][PW-1:0] pts_t;     // [point][axis]

    typedef struct packed {
        logic                 vld;
        logic [DW-1:0]        den;
        logic [2:0]           neg;
        logic [2:0][AW-1:0]   mag;
    } div_in_t;

    typedef struct packed {
        logic                 vld;
        logic [2:0][CW-1:0]   c;
    } coef_t;

    typedef struct packed {
        logic                     vld;
        logic [2:0][2:0][OW-1:0]  r;     // [kind][axis]
    } res_t;

    // Round half up and drop 30 fraction bits.
    function automatic logic signed [63:0] rs30(input logic signed [63:0] x);
        return (x + 64'sd536870912) >>> 30;
    endfunction

    // Dividend 2*x*2^24 + d for round-to-nearest division by 2*d.
    function automatic logic signed [NUMW-1:0] make_num(input logic signed [XW-1:0] x,
                                                        input logic signed [31:0] d);
        return (NUMW'(x) <<< (COEF_FRAC + 1)) + NUMW'(d);
    endfunction

    // Negative dividends divide as their one's complement; the quotient is
    // complemented back, which gives the floor.
    function automatic logic [AW-1:0] num_mag(input logic signed [NUMW-1:0] n);
        return n[NUMW-1] ? ~n[AW-1:0] : n[AW-1:0];
    endfunction

endpackage

// ===== hdl/rbz_coef.sv =====
`timescale 1ns / 1ps

module rbz_coef
    import rbz_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_vld,
    input  logic [TW-1:0]  t_in,
    output div_in_t        div_in [3]
);

    typedef struct packed {
        logic signed [31:0] t30, s30;
        logic signed [63:0] ss, ts, tt, mbp1;
    } c1_t;

    typedef struct packed {
        logic signed [31:0] b1, b3, ts;
        logic signed [32:0] bp0, bp1, bp2;
    } c2_t;

    typedef struct packed {
        logic signed [31:0] b1, b3;
        logic [2:0][32:0]   bp;
        logic signed [63:0] mb2;
    } c3_t;

    typedef struct packed {
        logic [2:0][31:0]   b;
        logic [2:0][32:0]   bp;
        logic signed [31:0] w, wp;
    } c4_t;

    typedef struct packed {
        logic [2:0][31:0]   b;
        logic [2:0][32:0]   bp;
        logic signed [31:0] w;
        logic signed [63:0] m_ww, m_wpw, m_wp2, m_wppw;
        logic [2:0][63:0]   m_bpw, m_bwp;
    } c5_t;

    typedef struct packed {
        logic [2:0][31:0]   b;
        logic [2:0][32:0]   bp;
        logic signed [31:0] w, ww, wpw, wp2, wppw;
        logic [2:0][XW-1:0] n1;
    } c6_t;

    typedef struct packed {
        logic [2:0][31:0]   b;
        logic signed [31:0] w, ww;
        logic [2:0][XW-1:0] n1;
        logic signed [63:0] m_www;
        logic [2:0][63:0]   t1, t2, t3, t4;
    } c7_t;

    typedef struct packed {
        logic [2:0][31:0]   b;
        logic signed [31:0] w, ww, www;
        logic [2:0][XW-1:0] n1, n2;
    } c8_t;

    typedef struct packed {
        logic [2:0][DW-1:0]         den;
        logic [2:0][2:0]            neg;
        logic [2:0][2:0][AW-1:0]    mag;
    } c9_t;

    logic [COEF_STAGES-1:0] vld_reg, vld_next;
    c1_t c1_reg, c1_next;
    c2_t c2_reg, c2_next;
    c3_t c3_reg, c3_next;
    c4_t c4_reg, c4_next;
    c5_t c5_reg, c5_next;
    c6_t c6_reg, c6_next;
    c7_t c7_reg, c7_next;
    c8_t c8_reg, c8_next;
    c9_t c9_reg, c9_next;

    // Clamp t, square terms and the middle slope product.
    always_comb begin : c1_logic
        logic [TW-1:0] t_sat;
        t_sat = (t_in > ONE_Q16) ? ONE_Q16 : t_in;
        c1_next.t30  = $signed({1'b0, t_sat, 14'd0});
        c1_next.s30  = $signed({1'b0, ONE_Q16 - t_sat, 14'd0});
        c1_next.ss   = 64'(c1_next.s30) * 64'(c1_next.s30);
        c1_next.ts   = 64'(c1_next.t30) * 64'(c1_next.s30);
        c1_next.tt   = 64'(c1_next.t30) * 64'(c1_next.t30);
        c1_next.mbp1 = 64'(SQRT2_Q30) * (64'(c1_next.s30) - 64'(c1_next.t30));
    end

    always_comb begin : c2_logic
        c2_next.b1  = 32'(rs30(c1_reg.ss));
        c2_next.b3  = 32'(rs30(c1_reg.tt));
        c2_next.ts  = 32'(rs30(c1_reg.ts));
        c2_next.bp1 = 33'(rs30(c1_reg.mbp1));
        c2_next.bp0 = -(33'(c1_reg.s30) <<< 1);
        c2_next.bp2 = 33'(c1_reg.t30) <<< 1;
    end

    always_comb begin : c3_logic
        c3_next.b1    = c2_reg.b1;
        c3_next.b3    = c2_reg.b3;
        c3_next.bp[0] = c2_reg.bp0;
        c3_next.bp[1] = c2_reg.bp1;
        c3_next.bp[2] = c2_reg.bp2;
        c3_next.mb2   = 64'(SQRT2_Q30) * 64'(c2_reg.ts);
    end

    // Weight and its slope.
    always_comb begin : c4_logic
        c4_next.b[0] = c3_reg.b1;
        c4_next.b[1] = 32'(rs30(c3_reg.mb2));
        c4_next.b[2] = c3_reg.b3;
        c4_next.bp   = c3_reg.bp;
        c4_next.w    = c3_reg.b1 + $signed(c4_next.b[1]) + c3_reg.b3;
        c4_next.wp   = 32'(34'($signed(c3_reg.bp[0])) + 34'($signed(c3_reg.bp[1]))
                           + 34'($signed(c3_reg.bp[2])));
    end

    always_comb begin : c5_logic
        c5_next.b      = c4_reg.b;
        c5_next.bp     = c4_reg.bp;
        c5_next.w      = c4_reg.w;
        c5_next.m_ww   = 64'(c4_reg.w) * 64'(c4_reg.w);
        c5_next.m_wpw  = 64'(c4_reg.wp) * 64'(c4_reg.w);
        c5_next.m_wp2  = 64'(c4_reg.wp) * 64'(c4_reg.wp);
        c5_next.m_wppw = 64'(WPP_Q30) * 64'(c4_reg.w);
        for (int i = 0; i < 3; i++) begin
            c5_next.m_bpw[i] = 64'($signed(c4_reg.bp[i])) * 64'(c4_reg.w);
            c5_next.m_bwp[i] = 64'($signed(c4_reg.b[i])) * 64'(c4_reg.wp);
        end
    end

    // Weight powers and first derivative numerators.
    always_comb begin : c6_logic
        c6_next.b    = c5_reg.b;
        c6_next.bp   = c5_reg.bp;
        c6_next.w    = c5_reg.w;
        c6_next.ww   = 32'(rs30(c5_reg.m_ww));
        c6_next.wpw  = 32'(rs30(c5_reg.m_wpw));
        c6_next.wp2  = 32'(rs30(c5_reg.m_wp2));
        c6_next.wppw = 32'(rs30(c5_reg.m_wppw));
        for (int i = 0; i < 3; i++) begin
            c6_next.n1[i] = XW'(rs30($signed(c5_reg.m_bpw[i]) - $signed(c5_reg.m_bwp[i])));
        end
    end

    always_comb begin : c7_logic
        c7_next.b     = c6_reg.b;
        c7_next.w     = c6_reg.w;
        c7_next.ww    = c6_reg.ww;
        c7_next.n1    = c6_reg.n1;
        c7_next.m_www = 64'(c6_reg.ww) * 64'(c6_reg.w);
        for (int i = 0; i < 3; i++) begin
            c7_next.t1[i] = 64'($signed(BPP[i])) * 64'(c6_reg.ww);
            c7_next.t2[i] = 64'($signed(c6_reg.bp[i])) * 64'(c6_reg.wpw);
            c7_next.t3[i] = 64'($signed(c6_reg.b[i])) * 64'(c6_reg.wppw);
            c7_next.t4[i] = 64'($signed(c6_reg.b[i])) * 64'(c6_reg.wp2);
        end
    end

    // Second derivative numerators.
    always_comb begin : c8_logic
        c8_next.b   = c7_reg.b;
        c8_next.w   = c7_reg.w;
        c8_next.ww  = c7_reg.ww;
        c8_next.n1  = c7_reg.n1;
        c8_next.www = 32'(rs30(c7_reg.m_www));
        for (int i = 0; i < 3; i++) begin
            c8_next.n2[i] = XW'(rs30($signed(c7_reg.t1[i]) - ($signed(c7_reg.t2[i]) <<< 1)
                                    - $signed(c7_reg.t3[i]) + ($signed(c7_reg.t4[i]) <<< 1)));
        end
    end

    // Dividends and divisors for the point, first and second coefficients.
    always_comb begin : c9_logic
        logic signed [NUMW-1:0] num;
        c9_next.den[0] = {c8_reg.w[DW-2:0], 1'b0};
        c9_next.den[1] = {c8_reg.ww[DW-2:0], 1'b0};
        c9_next.den[2] = {c8_reg.www[DW-2:0], 1'b0};
        for (int i = 0; i < 3; i++) begin
            num = make_num(XW'($signed(c8_reg.b[i])), c8_reg.w);
            c9_next.neg[0][i] = num[NUMW-1];
            c9_next.mag[0][i] = num_mag(num);
            num = make_num($signed(c8_reg.n1[i]), c8_reg.ww);
            c9_next.neg[1][i] = num[NUMW-1];
            c9_next.mag[1][i] = num_mag(num);
            num = make_num($signed(c8_reg.n2[i]), c8_reg.www);
            c9_next.neg[2][i] = num[NUMW-1];
            c9_next.mag[2][i] = num_mag(num);
        end
    end

    assign vld_next = {vld_reg[COEF_STAGES-2:0], in_vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_reg <= c1_next;
        c2_reg <= c2_next;
        c3_reg <= c3_next;
        c4_reg <= c4_next;
        c5_reg <= c5_next;
        c6_reg <= c6_next;
        c7_reg <= c7_next;
        c8_reg <= c8_next;
        c9_reg <= c9_next;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            div_in[k].vld = vld_reg[COEF_STAGES-1];
            div_in[k].den = c9_reg.den[k];
            div_in[k].neg = c9_reg.neg[k];
            div_in[k].mag = c9_reg.mag[k];
        end
    end

endmodule

// ===== hdl/rbz_div.sv =====
`timescale 1ns / 1ps
`include "rational_bezier_point_and_derivatives_assert.svh"

module rbz_div
    import rbz_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_in_t  din,
    output coef_t    dout
);

    // Three lanes share one divisor; one quotient bit per stage.
    logic [QW-1:0]                  vld_reg, vld_next;
    logic [QW-1:0][DW-1:0]          den_reg, den_next;
    logic [QW-1:0][2:0]             neg_reg, neg_next;
    logic [QW-1:0][2:0][RW-1:0]     rem_reg, rem_next;
    logic [QW-1:0][2:0][QW-1:0]     lq_reg, lq_next;   // dividend bits out, quotient in

    logic [QW:0][DW-1:0]            den_src;
    logic [QW:0][2:0]               neg_src;
    logic [QW:0][2:0][RW-1:0]       rem_src;
    logic [QW:0][2:0][QW-1:0]       lq_src;

    logic                           out_vld_reg, out_vld_next;
    logic [2:0][CW-1:0]             c_reg, c_next;

    always_comb begin : src_mux
        den_src[0] = din.den;
        neg_src[0] = din.neg;
        for (int l = 0; l < 3; l++) begin
            rem_src[0][l] = RW'(din.mag[l][AW-1:QW]);
            lq_src[0][l]  = din.mag[l][QW-1:0];
        end
        for (int j = 0; j < QW; j++) begin
            den_src[j+1] = den_reg[j];
            neg_src[j+1] = neg_reg[j];
            rem_src[j+1] = rem_reg[j];
            lq_src[j+1]  = lq_reg[j];
        end
    end

    always_comb begin : bit_stages
        logic [RW:0] trial;
        logic        ge;
        for (int j = 0; j < QW; j++) begin
            den_next[j] = den_src[j];
            neg_next[j] = neg_src[j];
            for (int l = 0; l < 3; l++) begin
                trial = {rem_src[j][l], lq_src[j][l][QW-1]};
                ge    = (trial >= {1'b0, den_src[j]});
                rem_next[j][l] = ge ? RW'(trial - {1'b0, den_src[j]}) : RW'(trial);
                lq_next[j][l]  = {lq_src[j][l][QW-2:0], ge};
            end
        end
    end

    assign vld_next     = {vld_reg[QW-2:0], din.vld};
    assign out_vld_next = vld_reg[QW-1];

    // Flip the quotient back for negative dividends.
    always_comb begin : sign_fix
        for (int l = 0; l < 3; l++) begin
            c_next[l] = neg_src[QW][l] ? ~{1'b0, lq_src[QW][l]} : {1'b0, lq_src[QW][l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        lq_reg  <= lq_next;
        c_reg   <= c_next;
    end

    assign dout.vld = out_vld_reg;
    assign dout.c   = c_reg;

    `RBZ_ASSERT_IMP(a_den_nonzero, clk, rst_n, din.vld, din.den != '0, "divisor is zero")
    `RBZ_ASSERT_IMP(a_rem_below_den, clk, rst_n, vld_reg[QW-1], (rem_reg[QW-1][0] < den_reg[QW-1]) && (rem_reg[QW-1][1] < den_reg[QW-1]) && (rem_reg[QW-1][2] < den_reg[QW-1]), "remainder not below divisor")
    `RBZ_ASSERT_IMP(a_div_latency, clk, rst_n, out_vld_reg, $past(din.vld, QW + 1), "quotient without a dividend")

endmodule

// ===== hdl/rbz_mac.sv =====
`timescale 1ns / 1ps

module rbz_mac
    import rbz_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  coef_t  cf [3],
    input  pts_t   pts,
    output res_t   res
);

    logic [MAC_STAGES-1:0]          vld_reg, vld_next;
    logic [2:0][2:0][2:0][63:0]     prod_reg, prod_next;   // [kind][axis][point]
    logic [2:0][2:0][63:0]          acc_reg, acc_next;     // [kind][axis]
    logic [2:0][2:0][OW-1:0]        r_reg, r_next;

    // Multiply coefficients by control points; unused axes stay zero.
    always_comb begin : mul_stage
        prod_next = '0;
        for (int k = 0; k < 3; k++) begin
            for (int d = 0; d < DIMENSION; d++) begin
                for (int i = 0; i < 3; i++) begin
                    prod_next[k][d][i] = 64'($signed(cf[k].c[i])) * 64'($signed(pts[i][d]));
                end
            end
        end
    end

    always_comb begin : sum_stage
        for (int k = 0; k < 3; k++) begin
            for (int d = 0; d < 3; d++) begin
                acc_next[k][d] = prod_reg[k][d][0] + prod_reg[k][d][1] + prod_reg[k][d][2];
            end
        end
    end

    // Round to Q32.16 and saturate.
    always_comb begin : round_stage
        logic signed [63:0] r64;
        for (int k = 0; k < 3; k++) begin
            for (int d = 0; d < 3; d++) begin
                r64 = ($signed(acc_reg[k][d]) + 64'sd8388608) >>> OUT_SHIFT;
                if (r64 > MAX48)
                begin
                    r_next[k][d] = OW'(MAX48);
                end
                else if (r64 < MIN48)
                begin
                    r_next[k][d] = OW'(MIN48);
                end
                else
                begin
                    r_next[k][d] = OW'(r64);
                end
            end
        end
    end

    assign vld_next = {vld_reg[MAC_STAGES-2:0], cf[0].vld & cf[1].vld & cf[2].vld};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
    end

    assign res.vld = vld_reg[MAC_STAGES-1];
    assign res.r   = r_reg;

endmodule

// ===== hdl/rational_bezier_point_and_derivatives.sv =====
// Channel   Handshake        Ports
// input     start / busy     t_param, p1_x .. p3_z
// result    done (strobe)    pos_x .. pos_z, d1_x .. d1_z, d2_x .. d2_z
//
// One word enters per cycle; its result is taken at the rising edge that ends
// the cycle in which done is high.
// The pipeline is 9 coefficient stages, 31 divider stages (30 quotient bits plus
// a sign fix) and a 3-stage multiply-accumulate.
// rst_n clears every valid bit at once; data registers are not reset.
// No stalls: busy stays low and each result shows for exactly one cycle.
`timescale 1ns / 1ps
`include "rational_bezier_point_and_derivatives_assert.svh"

module rational_bezier_point_and_derivatives
    import rbz_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [TW-1:0]         t_param,
    input  logic signed [PW-1:0]  p1_x,
    input  logic signed [PW-1:0]  p1_y,
    input  logic signed [PW-1:0]  p1_z,
    input  logic signed [PW-1:0]  p2_x,
    input  logic signed [PW-1:0]  p2_y,
    input  logic signed [PW-1:0]  p2_z,
    input  logic signed [PW-1:0]  p3_x,
    input  logic signed [PW-1:0]  p3_y,
    input  logic signed [PW-1:0]  p3_z,
    output logic                  done,
    output logic signed [OW-1:0]  pos_x,
    output logic signed [OW-1:0]  pos_y,
    output logic signed [OW-1:0]  pos_z,
    output logic signed [OW-1:0]  d1_x,
    output logic signed [OW-1:0]  d1_y,
    output logic signed [OW-1:0]  d1_z,
    output logic signed [OW-1:0]  d2_x,
    output logic signed [OW-1:0]  d2_y,
    output logic signed [OW-1:0]  d2_z
);

    logic                       in_vld;
    pts_t                       pts_in;
    pts_t [PT_DEPTH-1:0]        pt_reg, pt_next;
    div_in_t                    div_in [3];
    coef_t                      coef [3];
    res_t                       res;

    // The pipeline never holds a word back, so busy stays low.
    assign busy   = 1'b0;
    assign in_vld = start & ~busy;

    // Pack control points as [point][axis].
    assign pts_in[0][0] = p1_x;
    assign pts_in[0][1] = p1_y;
    assign pts_in[0][2] = p1_z;
    assign pts_in[1][0] = p2_x;
    assign pts_in[1][1] = p2_y;
    assign pts_in[1][2] = p2_z;
    assign pts_in[2][0] = p3_x;
    assign pts_in[2][1] = p3_y;
    assign pts_in[2][2] = p3_z;

    // Delay the points so they meet their coefficients at the multipliers.
    // Advance every cycle; each word moves in lockstep with its valid bit.
    assign pt_next = {pt_reg[PT_DEPTH-2:0], pts_in};

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    // Bernstein terms, weight powers and coefficient dividends from t.
    rbz_coef u_coef (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (in_vld),
        .t_in   (t_param),
        .div_in (div_in)
    );

    // One divider per coefficient kind: point, first and second derivative.
    for (genvar k = 0; k < 3; k++) begin : g_div
        rbz_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (div_in[k]),
            .dout  (coef[k])
        );
    end

    // Weighted sums over control points, round and saturate.
    rbz_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cf    (coef),
        .pts   (pt_reg[PT_DEPTH-1]),
        .res   (res)
    );

    assign done  = res.vld;
    assign pos_x = res.r[0][0];
    assign pos_y = res.r[0][1];
    assign pos_z = res.r[0][2];
    assign d1_x  = res.r[1][0];
    assign d1_y  = res.r[1][1];
    assign d1_z  = res.r[1][2];
    assign d2_x  = res.r[2][0];
    assign d2_y  = res.r[2][1];
    assign d2_z  = res.r[2][2];

    `RBZ_ASSERT_IMP(a_done_has_word, clk, rst_n, done, $past(start && !busy, LATENCY), "result without an accepted word")
    `RBZ_ASSERT_IMP(a_word_gives_done, clk, rst_n, start && !busy, ##LATENCY done, "accepted word gave no result")

endmodule

// ===== tb/bezier_checker.sv =====
`timescale 1ns / 1ps

module bezier_checker
    import rbz_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [TW-1:0]         t_param,
    input  logic [2:0][2:0][PW-1:0] ctrl_pts,   // [point][axis]
    input  logic                  done,
    input  logic [8:0][OW-1:0]    curve_out,  // pos xyz, d1 xyz, d2 xyz
    output int                    fails,
    output int                    pending
);

    typedef logic [8:0][OW-1:0] curve_word_t;

    curve_word_t expected_curve[$];

    string field_name[9] = '{"pos_x", "pos_y", "pos_z", "d1_x", "d1_y", "d1_z",
                             "d2_x", "d2_y", "d2_z"};

    function automatic longint round_shift(longint x, int k);
        return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    // Round to nearest, halves upward, for a positive divisor.
    function automatic longint div_round(longint n, longint d);
        longint num;
        longint den;
        longint q;
        num = 2 * n + d;
        den = 2 * d;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q -= 1;
        return q;
    endfunction

    function automatic logic [OW-1:0] sat48(longint acc);
        longint r;
        r = round_shift(acc, OUT_SHIFT);
        if (r > MAX48)
            r = MAX48;
        if (r < MIN48)
            r = MIN48;
        return r[OW-1:0];
    endfunction

    function automatic curve_word_t eval_curve(logic [TW-1:0] t,
                                               logic [2:0][2:0][PW-1:0] p);
        longint tq, t30, s30, sq2;
        longint b[3], bp[3], bpp[3], c0[3], c1[3], c2[3];
        longint w, wp, wpp, ww, www, wpw, wp2, wppw, n1, n2;
        longint a0, a1, a2, pv;
        curve_word_t r;
        sq2 = longint'(SQRT2_Q30);
        tq = (t > ONE_Q16) ? 65536 : longint'(t);
        t30 = tq <<< 14;
        s30 = (65536 - tq) <<< 14;
        b[0] = round_shift(s30 * s30, 30);
        b[1] = round_shift(sq2 * round_shift(t30 * s30, 30), 30);
        b[2] = round_shift(t30 * t30, 30);
        bp[0] = -2 * s30;
        bp[1] = round_shift(sq2 * (s30 - t30), 30);
        bp[2] = 2 * t30;
        bpp[0] = 64'sd1 <<< 31;
        bpp[1] = -2 * sq2;
        bpp[2] = 64'sd1 <<< 31;
        w = b[0] + b[1] + b[2];
        wp = bp[0] + bp[1] + bp[2];
        wpp = bpp[0] + bpp[1] + bpp[2];
        ww = round_shift(w * w, 30);
        www = round_shift(ww * w, 30);
        wpw = round_shift(wp * w, 30);
        wp2 = round_shift(wp * wp, 30);
        wppw = round_shift(wpp * w, 30);
        for (int i = 0; i < 3; i++)
        begin
            n1 = bp[i] * w - b[i] * wp;
            n2 = bpp[i] * ww - 2 * bp[i] * wpw - b[i] * wppw + 2 * b[i] * wp2;
            c0[i] = div_round(b[i] <<< COEF_FRAC, w);
            c1[i] = div_round(round_shift(n1, 30) <<< COEF_FRAC, ww);
            c2[i] = div_round(round_shift(n2, 30) <<< COEF_FRAC, www);
        end
        for (int d = 0; d < 3; d++)
        begin
            a0 = 0;
            a1 = 0;
            a2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                pv = longint'($signed(p[i][d]));
                a0 += c0[i] * pv;
                a1 += c1[i] * pv;
                a2 += c2[i] * pv;
            end
            if (d >= DIMENSION)
            begin
                r[d] = '0;
                r[3 + d] = '0;
                r[6 + d] = '0;
            end
            else
            begin
                r[d] = sat48(a0);
                r[3 + d] = sat48(a1);
                r[6 + d] = sat48(a2);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_word_t exp_w;
        if (!rst_n)
        begin
            expected_curve.delete();
            fails = 0;
        end
        else
        begin
            if (start && !busy)
                expected_curve.push_back(eval_curve(t_param, ctrl_pts));
            if (done)
            begin
                if (expected_curve.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fails++;
                end
                else
                begin
                    exp_w = expected_curve.pop_front();
                    for (int f = 0; f < 9; f++)
                        if (curve_out[f] !== exp_w[f])
                        begin
                            $error("%s: expected %0d, actual %0d", field_name[f],
                                   $signed(exp_w[f]), $signed(curve_out[f]));
                            fails++;
                        end
                end
            end
        end
        pending = expected_curve.size();
    end

endmodule

// ===== tb/rational_bezier_point_and_derivatives_test.sv =====
`timescale 1ns / 1ps

module rational_bezier_point_and_derivatives_test;
    import rbz_pkg::*;

    // Quiet cycles with no word moving on either side before the run is
    // declared hung; covers the longest sender gap plus pipeline latency.
    localparam int HANG_LIMIT = 4000;
    localparam int RANDOM_WORDS = 1200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    logic [TW-1:0] t_param = '0;
    logic [2:0][2:0][PW-1:0] pts = '0;   // [point][axis]
    logic [8:0][OW-1:0] curve_out;
    int fails;
    int pending;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    rational_bezier_point_and_derivatives dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .t_param(t_param),
        .p1_x(pts[0][0]), .p1_y(pts[0][1]), .p1_z(pts[0][2]),
        .p2_x(pts[1][0]), .p2_y(pts[1][1]), .p2_z(pts[1][2]),
        .p3_x(pts[2][0]), .p3_y(pts[2][1]), .p3_z(pts[2][2]),
        .done(done),
        .pos_x(curve_out[0]), .pos_y(curve_out[1]), .pos_z(curve_out[2]),
        .d1_x(curve_out[3]), .d1_y(curve_out[4]), .d1_z(curve_out[5]),
        .d2_x(curve_out[6]), .d2_y(curve_out[7]), .d2_z(curve_out[8])
    );

    bezier_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .t_param(t_param), .ctrl_pts(pts), .done(done), .curve_out(curve_out),
        .fails(fails), .pending(pending)
    );

    // Reset the hang counter whenever a word moves on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("rational_bezier_point_and_derivatives verification failed");
            $finish;
        end
    end

    // Mostly back to back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // Drop start for the gap, present the word and hold it until busy is
    // low at an edge. busy only moves on a rising edge, so the value seen
    // at the falling edge is the one the next rising edge will use.
    task automatic send_word(logic [TW-1:0] t, logic [2:0][2:0][PW-1:0] p, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        t_param <= t;
        pts <= p;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Hold the sender off until the checker has nothing outstanding.
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [PW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom();                                  // full range
        if (r < 8)
            return PW'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
        return (r == 8) ? 32'h7FFFFFFF : 32'h80000000;
    endfunction

    function automatic logic [TW-1:0] rand_t();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return TW'($urandom_range(0, 65536));
        if (r < 18)
            return TW'($urandom_range(65537, 131071));   // clamped to one
        return (r == 18) ? 17'd0 : 17'd65536;
    endfunction

    initial
    begin
        logic [2:0][2:0][PW-1:0] p;
        logic [TW-1:0] dir_t[8];
        dir_t = '{17'd0, 17'd65536, 17'd32768, 17'd1, 17'd65535,
                  17'd65537, 17'd131071, 17'd16384};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: parameter extremes and the clamp above one, each against
        // positive full-scale, negative full-scale and mixed-sign control points.
        foreach (dir_t[k])
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < 3; i++)
                    for (int d = 0; d < 3; d++)
                        case (c)
                            0: p[i][d] = 32'h7FFFFFFF;
                            1: p[i][d] = 32'h80000000;
                            default: p[i][d] = ((i + d) % 2) ? 32'h80000000 : 32'h7FFFFFFF;
                        endcase
                send_word(dir_t[k], p, 0);
            end
        end
        send_word(17'd40000, '0, 0);
        drain();

        // Random words; make the sender wait out the pipeline once midway.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            for (int i = 0; i < 3; i++)
                for (int d = 0; d < 3; d++)
                    p[i][d] = rand_coord();
            send_word(rand_t(), p, pick_gap());
            if (n == RANDOM_WORDS / 2)
                drain();
        end
        start <= 1'b0;

        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fails == 0)
            $display("rational_bezier_point_and_derivatives verification clean");
        else
            $display("rational_bezier_point_and_derivatives verification failed");
        $finish;
    end

endmodule
